// ----- rtl/fclp_pkg.sv -----
// Package: shared types and constants for the flow cache.
package fclp_pkg;

    localparam int unsigned SETS_DEF     = 1024;
    localparam int unsigned WAYS_DEF     = 4;
    localparam int unsigned KEY_BITS_DEF = 48;
    localparam int unsigned WAY_LIMIT    = 4;

    localparam int unsigned OUT_KEY_W = 48;
    localparam int unsigned HASH_W    = 16;
    localparam int unsigned SETIDX_W  = 10;
    localparam int unsigned NSETS_W   = 11;
    localparam int unsigned NWAYS_W   = 3;
    localparam int unsigned OP_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_ACCESS = 2'd1,
        OP_UPDATE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic {
        REG_NUM_SETS = 1'b0,
        REG_WAYS     = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_EXEC,
        ST_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic clr_step;
        logic load;
        logic mod_step;
        logic rd;
        logic exec;
        logic out_load;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic clr_done;
        logic mod_done;
    } t_sts;

endpackage

// ----- rtl/fclp_if.sv -----
// Interfaces: valid/ready item channels and the configuration write channel.
interface fclp_in_if #(
    parameter int unsigned KEY_W = 48
);
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [KEY_W-1:0]   flow_key;
    logic [15:0]        hash_value;
    modport source (output valid, opcode, flow_key, hash_value, input ready);
    modport sink   (input valid, opcode, flow_key, hash_value, output ready);
endinterface

interface fclp_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic        refused;
    logic        evicted_valid;
    logic [47:0] evicted_key;
    logic [9:0]  set_index;
    modport source (output valid, found, refused, evicted_valid, evicted_key, set_index,
                    input ready);
    modport sink   (input valid, found, refused, evicted_valid, evicted_key, set_index,
                    output ready);
endinterface

interface fclp_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [10:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/fclp_ctrl.sv -----
// Controller: sequences clear, set-index reduction, set read, execute and output.
module fclp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  fclp_pkg::t_sts i_sts,
    output fclp_pkg::t_cmd o_cmd
);
    import fclp_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (i_sts.clr_done) n_state = ST_IDLE;
            ST_IDLE:  if (i_in_valid) n_state = ST_MOD;
            ST_MOD:   if (i_sts.mod_done) n_state = ST_READ;
            ST_READ:  n_state = ST_EXEC;
            ST_EXEC:  n_state = ST_OUT;
            ST_OUT: begin
                if (i_out_ready) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_CLEAR: o_cmd.clr_step = 1'b1;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                o_cmd.rd       = i_sts.mod_done;
            end
            ST_READ: ;
            ST_EXEC: begin
                o_cmd.exec     = 1'b1;
                o_cmd.out_load = 1'b1;
            end
            ST_OUT:  o_out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

// ----- rtl/fclp_dp.sv -----
// Datapath: set index divider, set memory, way compare and LRU reordering.
module fclp_dp #(
    parameter int unsigned SETS     = fclp_pkg::SETS_DEF,
    parameter int unsigned WAYS     = fclp_pkg::WAYS_DEF,
    parameter int unsigned KEY_BITS = fclp_pkg::KEY_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fclp_pkg::t_cmd                     i_cmd,
    output fclp_pkg::t_sts                     o_sts,
    input  logic [1:0]                         i_opcode,
    input  logic [KEY_BITS-1:0]                i_flow_key,
    input  logic [15:0]                        i_hash_value,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [10:0]                        i_cfg_data,
    output logic                               o_found,
    output logic                               o_refused,
    output logic                               o_evicted_valid,
    output logic [47:0]                        o_evicted_key,
    output logic [9:0]                         o_set_index
);
    import fclp_pkg::*;

    localparam int unsigned SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int unsigned CNT_W  = $clog2(SETS + 1);
    localparam int unsigned NW     = (WAYS < WAY_LIMIT) ? WAYS : WAY_LIMIT;
    localparam int unsigned FILL_W = $clog2(WAYS + 1);
    localparam int unsigned POS_W  = (NW > 1) ? $clog2(NW) : 1;
    localparam int unsigned DIV_W  = (CNT_W > HASH_W) ? CNT_W : HASH_W;

    typedef struct packed {
        logic [NW-1:0][KEY_BITS-1:0] key;
        logic [NW-1:0]               pin;
        logic [FILL_W-1:0]           fill;
    } t_row;

    // configuration
    logic [NSETS_W-1:0] r_num_sets;
    logic [NWAYS_W-1:0] r_ways;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_sets <= NSETS_W'(1024);
            r_ways     <= NWAYS_W'(4);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_NUM_SETS) r_num_sets <= i_cfg_data;
            else                             r_ways     <= i_cfg_data[NWAYS_W-1:0];
        end
    end

    // clear sweep
    logic [SET_W-1:0] r_clr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (i_cmd.clr_step) r_clr <= r_clr + SET_W'(1);
    end
    assign o_sts.clr_done = (r_clr == SET_W'(SETS - 1));

    // item registers and restoring divider, one quotient bit a cycle
    logic [1:0]          r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [DIV_W-1:0]    r_ns, r_rem;
    logic [HASH_W-1:0]   r_dvd;
    logic [4:0]          r_cnt;
    logic [DIV_W:0]      w_trial;
    logic [DIV_W-1:0]    w_ns;

    always_comb begin
        w_ns = DIV_W'(r_num_sets);
        if (r_num_sets == '0) w_ns = DIV_W'(1);
        if (32'(r_num_sets) > SETS) w_ns = DIV_W'(SETS);
    end
    assign w_trial = {r_rem, r_dvd[HASH_W-1]} - {1'b0, r_ns};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.mod_step && !o_sts.mod_done) begin
            r_cnt <= r_cnt + 5'd1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_key <= i_flow_key;
            r_dvd <= i_hash_value;
            r_rem <= '0;
            r_ns  <= w_ns;
        end else if (i_cmd.mod_step && !o_sts.mod_done) begin
            r_dvd <= {r_dvd[HASH_W-2:0], 1'b0};
            if (!w_trial[DIV_W]) r_rem <= w_trial[DIV_W-1:0];
            else                 r_rem <= {r_rem[DIV_W-2:0], r_dvd[HASH_W-1]};
        end
    end
    assign o_sts.mod_done = (r_cnt == 5'(HASH_W));

    logic [SET_W-1:0] w_set;
    assign w_set = r_rem[SET_W-1:0];

    // set memory, one row per set
    t_row mem [SETS];
    t_row r_row, w_wr;
    logic w_we;
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step)  mem[r_clr] <= '0;
        else if (w_we)       mem[w_set] <= w_wr;
        if (i_cmd.rd)        r_row      <= mem[w_set];
    end

    // execute
    logic [FILL_W-1:0] w_fill, w_cap;
    logic [POS_W-1:0]  w_pos, w_last;
    logic              w_hit, w_found, w_ref, w_ev;
    logic [KEY_BITS-1:0] w_evk;

    always_comb begin
        w_fill = r_row.fill;
        w_cap  = FILL_W'(r_ways);
        if (r_ways == '0) w_cap = FILL_W'(1);
        if (32'(r_ways) > NW) w_cap = FILL_W'(NW);
        w_last = POS_W'(w_fill - FILL_W'(1));
        w_hit  = 1'b0;
        w_pos  = '0;
        for (int i = NW - 1; i >= 0; i--) begin
            if (FILL_W'(i) < w_fill && r_row.key[i] == r_key) begin
                w_hit = 1'b1;
                w_pos = POS_W'(i);
            end
        end
        w_wr    = r_row;
        w_we    = 1'b0;
        w_found = 1'b0;
        w_ref   = 1'b0;
        w_ev    = 1'b0;
        w_evk   = '0;
        case (r_op)
            OP_INSERT: begin
                if (w_fill >= w_cap) begin
                    if (r_row.pin[w_last]) begin
                        w_ref = 1'b1;
                    end else begin
                        w_ev  = 1'b1;
                        w_evk = r_row.key[w_last];
                        w_we  = 1'b1;
                        for (int i = 1; i < NW; i++) begin
                            if (POS_W'(i) <= w_last) begin
                                w_wr.key[i] = r_row.key[i-1];
                                w_wr.pin[i] = r_row.pin[i-1];
                            end
                        end
                        w_wr.key[0] = r_key;
                        w_wr.pin[0] = 1'b0;
                    end
                end else begin
                    w_we = 1'b1;
                    for (int i = 1; i < NW; i++) begin
                        if (FILL_W'(i) <= w_fill) begin
                            w_wr.key[i] = r_row.key[i-1];
                            w_wr.pin[i] = r_row.pin[i-1];
                        end
                    end
                    w_wr.key[0] = r_key;
                    w_wr.pin[0] = 1'b0;
                    w_wr.fill   = w_fill + FILL_W'(1);
                end
            end
            OP_ACCESS: begin
                if (w_hit) begin
                    w_found = 1'b1;
                    w_we    = 1'b1;
                    for (int i = 1; i < NW; i++) begin
                        if (POS_W'(i) <= w_pos) begin
                            w_wr.key[i] = r_row.key[i-1];
                            w_wr.pin[i] = r_row.pin[i-1];
                        end
                    end
                    w_wr.key[0] = r_key;
                    w_wr.pin[0] = 1'b1;
                end
            end
            OP_UPDATE: begin
                if (w_hit) begin
                    w_found          = 1'b1;
                    w_we             = 1'b1;
                    w_wr.pin[w_pos]  = 1'b0;
                end
            end
            default: ;
        endcase
        w_we = w_we & i_cmd.exec;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_found         <= w_found;
            o_refused       <= w_ref;
            o_evicted_valid <= w_ev;
            o_evicted_key   <= OUT_KEY_W'(w_evk);
            o_set_index     <= SETIDX_W'(w_set);
        end
    end
endmodule

// ----- rtl/flow_cache_lru_with_pin_unit.sv -----
// Top level: flow cache with LRU order and pinning, controller plus datapath.
// Result path: a 16-step set index divider, the set memory read, an idle read
//   state and an execute state, after which the registered result is valid.
// Flow: one item in flight at a time; a new item is taken only once the last result is out.
// Reset: synchronous active low; then a clearing pass over all SETS sets (1024 by
//   default) empties every set, during which no item is taken.
module flow_cache_lru_with_pin_unit #(
    parameter int unsigned SETS     = fclp_pkg::SETS_DEF,
    parameter int unsigned WAYS     = fclp_pkg::WAYS_DEF,
    parameter int unsigned KEY_BITS = fclp_pkg::KEY_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fclp_in_if.sink    in_ch,
    fclp_out_if.source out_ch,
    fclp_cfg_if.sink   cfg_ch
);
    import fclp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // config writes are always taken
    assign cfg_ch.ready = 1'b1;

    fclp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .o_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // keys masked to KEY_BITS on entry
    fclp_dp #(.SETS(SETS), .WAYS(WAYS), .KEY_BITS(KEY_BITS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_opcode       (in_ch.opcode),
        .i_flow_key     (in_ch.flow_key[KEY_BITS-1:0]),
        .i_hash_value   (in_ch.hash_value),
        .i_cfg_we       (cfg_ch.valid),
        .i_cfg_index    (cfg_ch.index),
        .i_cfg_data     (cfg_ch.data),
        .o_found        (out_ch.found),
        .o_refused      (out_ch.refused),
        .o_evicted_valid(out_ch.evicted_valid),
        .o_evicted_key  (out_ch.evicted_key),
        .o_set_index    (out_ch.set_index)
    );
endmodule

// ----- rtl/fclp_chk.sv -----
// Checker: port-level properties of the flow cache, bound to the top level.
module fclp_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_found,
    input logic       i_refused,
    input logic       i_evicted_valid
);
    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_refused && i_evicted_valid) && !(i_found && i_refused))
        else $error("conflicting result flags");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input taken while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped");
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_out_valid)
        else $error("result too early");
endmodule

bind flow_cache_lru_with_pin_unit fclp_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (in_ch.valid),
    .i_in_ready     (in_ch.ready),
    .i_out_valid    (out_ch.valid),
    .i_out_ready    (out_ch.ready),
    .i_found        (out_ch.found),
    .i_refused      (out_ch.refused),
    .i_evicted_valid(out_ch.evicted_valid)
);

// ----- verif/flow_cache_lru_with_pin_unit_tb.sv -----
// Testbench: directed table plus random traffic checked against a cache predictor.
`timescale 1ns / 100ps

module flow_cache_lru_with_pin_unit_tb;
    import fclp_pkg::*;

    localparam int unsigned N_SETS = 1024;
    localparam int unsigned N_WAYS = 4;
    localparam longint unsigned CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fclp_in_if #(.KEY_W(48)) in_ch ();
    fclp_out_if out_ch ();
    fclp_cfg_if cfg_ch ();

    flow_cache_lru_with_pin_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // One result per transfer in.
    typedef struct packed {
        logic        found;
        logic        refused;
        logic        ev_valid;
        logic [47:0] ev_key;
        logic [9:0]  set_idx;
    } t_cache_res;

    // Predictor state: per-set recency lists, position 0 is most recent.
    logic [47:0] pm_key [N_SETS][N_WAYS];
    logic        pm_pin [N_SETS][N_WAYS];
    int unsigned pm_fill [N_SETS];
    int unsigned pm_nsets;
    int unsigned pm_ways;

    t_cache_res  pending_res[$];
    int          err_cnt = 0;
    longint unsigned cycle_cnt = 0;
    bit          idle_enable = 1'b0;
    bit          hold_sink = 1'b0;

    // Hot keys and sets make hits, pins and refusals common.
    logic [47:0] hot_key [8];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
        err_cnt++;
    endtask

    // Move entry at pos to the front with the given pin.
    function automatic void lru_front(int unsigned s, int unsigned pos,
                                      logic [47:0] k, logic p);
        for (int unsigned i = pos; i > 0; i--) begin
            pm_key[s][i] = pm_key[s][i-1];
            pm_pin[s][i] = pm_pin[s][i-1];
        end
        pm_key[s][0] = k;
        pm_pin[s][0] = p;
    endfunction

    function automatic t_cache_res cache_predict(t_op op, logic [47:0] k, logic [15:0] h);
        t_cache_res r;
        int unsigned ns, s, fill, cap;
        r = '{1'b0, 1'b0, 1'b0, 48'd0, 10'd0};
        ns = (pm_nsets == 0) ? 1 : (pm_nsets > N_SETS ? N_SETS : pm_nsets);
        s = h % ns;
        fill = (pm_fill[s] > N_WAYS) ? N_WAYS : pm_fill[s];
        cap = (pm_ways == 0) ? 1 : (pm_ways > N_WAYS ? N_WAYS : pm_ways);
        r.set_idx = s[9:0];
        case (op)
            OP_INSERT: begin
                if (fill >= cap) begin
                    if (pm_pin[s][fill-1]) begin
                        r.refused = 1'b1;
                    end else begin
                        r.ev_valid = 1'b1;
                        r.ev_key = pm_key[s][fill-1];
                        lru_front(s, fill - 1, k, 1'b0);
                    end
                end else begin
                    lru_front(s, fill, k, 1'b0);
                    pm_fill[s] = fill + 1;
                end
            end
            OP_ACCESS, OP_UPDATE: begin
                for (int unsigned i = 0; i < fill; i++) begin
                    if (pm_key[s][i] == k) begin
                        r.found = 1'b1;
                        if (op == OP_ACCESS) lru_front(s, i, k, 1'b1);
                        else pm_pin[s][i] = 1'b0;
                        break;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic bit idle_roll();
        return idle_enable && ($urandom_range(99) < 28);
    endfunction

    // Send one item; prediction is taken at the transfer edge. Valid stays up
    // after the transfer so items can follow back to back.
    task automatic send_item(t_op op, logic [47:0] k, logic [15:0] h);
        while (idle_roll()) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.flow_key   <= k;
        in_ch.hash_value <= h;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_res.push_back(cache_predict(op, k, h));
    endtask

    task automatic cfg_write(t_reg_idx idx, logic [10:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == REG_NUM_SETS) pm_nsets = 32'(val);
        else pm_ways = 32'(val[2:0]);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // Result checker: sampled at the edge, compares with the oldest expectation.
    always @(posedge i_clk) begin
        t_cache_res e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_res.size() == 0) begin
                report("unexpected result", 64'd0, 64'd0);
            end else begin
                e = pending_res.pop_front();
                if (out_ch.found !== e.found)
                    report("found", 64'(out_ch.found), 64'(e.found));
                if (out_ch.refused !== e.refused)
                    report("refused", 64'(out_ch.refused), 64'(e.refused));
                if (out_ch.evicted_valid !== e.ev_valid)
                    report("evicted_valid", 64'(out_ch.evicted_valid), 64'(e.ev_valid));
                if (out_ch.evicted_key !== e.ev_key)
                    report("evicted_key", 64'(out_ch.evicted_key), 64'(e.ev_key));
                if (out_ch.set_index !== e.set_idx)
                    report("set_index", 64'(out_ch.set_index), 64'(e.set_idx));
            end
        end
    end

    // Receiver: random stalls, or a long hold-off while the sender keeps offering.
    always @(posedge i_clk) begin
        out_ch.ready <= !hold_sink && !idle_roll();
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[flow_cache_lru_with_pin_unit] ERROR");
            $finish;
        end
    end

    // Directed rows; an expected value is given only where obvious at a glance.
    typedef struct {
        t_op         op;
        logic [47:0] k;
        logic [15:0] h;
        bit          chk;
        t_cache_res  res;
    } t_row;

    t_row dir_rows [17] = '{
        // empty cache: misses, set index from full-range hash
        '{OP_ACCESS, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1, '{0, 0, 0, 48'd0, 10'd1023}},
        '{OP_UPDATE, 48'd0, 16'd0, 1, '{0, 0, 0, 48'd0, 10'd0}},
        '{OP_NONE, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1, '{0, 0, 0, 48'd0, 10'd1023}},
        // fill set 5 to four, then evict
        '{OP_INSERT, 48'h1, 16'd5, 1, '{0, 0, 0, 48'd0, 10'd5}},
        '{OP_INSERT, 48'hFFFF_FFFF_FFFF, 16'd1029, 0, '{0, 0, 0, 0, 0}},
        '{OP_INSERT, 48'h3, 16'd5, 0, '{0, 0, 0, 0, 0}},
        '{OP_INSERT, 48'h3, 16'd5, 0, '{0, 0, 0, 0, 0}},
        '{OP_INSERT, 48'h4, 16'd5, 1, '{0, 0, 1, 48'h1, 10'd5}},
        // duplicate: access pins most recent copy
        '{OP_ACCESS, 48'h3, 16'd5, 0, '{0, 0, 0, 0, 0}},
        '{OP_ACCESS, 48'hFFFF_FFFF_FFFF, 16'd5, 0, '{0, 0, 0, 0, 0}},
        '{OP_ACCESS, 48'h3, 16'd5, 0, '{0, 0, 0, 0, 0}},
        '{OP_ACCESS, 48'h4, 16'd5, 0, '{0, 0, 0, 0, 0}},
        // evict the unpinned tail, unpin, then a pinned tail refuses the insert
        '{OP_INSERT, 48'h9, 16'd5, 0, '{0, 0, 0, 0, 0}},
        '{OP_UPDATE, 48'h3, 16'd5, 0, '{0, 0, 0, 0, 0}},
        '{OP_INSERT, 48'h9, 16'd5, 0, '{0, 0, 0, 0, 0}},
        '{OP_UPDATE, 48'h77, 16'd5, 0, '{0, 0, 0, 0, 0}},
        '{OP_NONE, 48'h9, 16'd5, 0, '{0, 0, 0, 0, 0}}
    };

    function automatic logic [47:0] pick_key();
        if ($urandom_range(99) < 70) return hot_key[$urandom_range(7)];
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic logic [15:0] pick_hash();
        if ($urandom_range(99) < 60) return 16'($urandom_range(3)) * 16'd1024 +
                                          16'($urandom_range(3));
        return 16'($urandom());
    endfunction

    task automatic rand_phase(int n);
        t_op op;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(99)) inside
                [0:44]:  op = OP_INSERT;
                [45:74]: op = OP_ACCESS;
                [75:95]: op = OP_UPDATE;
                default: op = OP_NONE;
            endcase
            send_item(op, pick_key(), pick_hash());
        end
        in_ch.valid <= 1'b0;
    endtask

    initial begin
        t_cache_res e;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_NONE;
        in_ch.flow_key = '0;
        in_ch.hash_value = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_NUM_SETS;
        cfg_ch.data = '0;
        foreach (pm_fill[s]) begin
            pm_fill[s] = 0;
            for (int w = 0; w < N_WAYS; w++) begin
                pm_key[s][w] = '0;
                pm_pin[s][w] = 1'b0;
            end
        end
        pm_nsets = 1024;
        pm_ways = 4;
        for (int i = 0; i < 8; i++) hot_key[i] = 48'({$urandom(), $urandom()});
        hot_key[0] = 48'hFFFF_FFFF_FFFF;
        hot_key[1] = 48'd0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part; rows with a typed result are checked there as well.
        foreach (dir_rows[r]) begin
            send_item(dir_rows[r].op, dir_rows[r].k, dir_rows[r].h);
            e = pending_res[$];
            if (dir_rows[r].chk && e != dir_rows[r].res) report("table row", 64'(r), 64'd0);
        end
        in_ch.valid <= 1'b0;
        drain();

        // Long backpressure: sender keeps offering while the sink holds off.
        hold_sink = 1'b1;
        fork
            rand_phase(30);
            begin
                repeat (300) @(posedge i_clk);
                hold_sink = 1'b0;
            end
        join
        drain();

        // Random phases across settings, extremes included; first one without idling.
        cfg_write(REG_NUM_SETS, 11'd4);
        cfg_write(REG_WAYS, 11'd4);
        rand_phase(250);
        drain();
        idle_enable = 1'b1;
        cfg_write(REG_WAYS, 11'd2);   // lower capacity on full sets
        rand_phase(200);
        drain();
        cfg_write(REG_NUM_SETS, 11'd0);
        cfg_write(REG_WAYS, 11'd0);
        rand_phase(150);
        drain();
        cfg_write(REG_NUM_SETS, 11'd2047);
        cfg_write(REG_WAYS, 11'd7);
        rand_phase(200);
        drain();
        cfg_write(REG_NUM_SETS, 11'd1);
        cfg_write(REG_WAYS, 11'd1);
        rand_phase(150);
        drain();
        cfg_write(REG_NUM_SETS, 11'd1024);
        cfg_write(REG_WAYS, 11'd3);
        rand_phase(200);
        drain();
        cfg_write(REG_NUM_SETS, 11'd3);
        cfg_write(REG_WAYS, 11'd4);
        rand_phase(250);
        drain();

        if (err_cnt == 0 && pending_res.size() == 0) begin
            $display("[flow_cache_lru_with_pin_unit] OK");
        end else begin
            $display("[flow_cache_lru_with_pin_unit] ERROR");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/fclp_pkg.sv
rtl/fclp_if.sv
rtl/fclp_ctrl.sv
rtl/fclp_dp.sv
rtl/flow_cache_lru_with_pin_unit.sv
rtl/fclp_chk.sv
verif/flow_cache_lru_with_pin_unit_tb.sv
